// ===== rtl/sorted_deadline_timer_queue_defines.svh =====
// Assertion macros for the sorted deadline timer queue.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SDTQ_ASSERT_CLK(label, clk_s, rst_n_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);
`define SDTQ_ASSERT(label, prop, msg) `SDTQ_ASSERT_CLK(label, clk, arst_n, prop, msg)
`else
`define SDTQ_ASSERT_CLK(label, clk_s, rst_n_s, prop, msg)
`define SDTQ_ASSERT(label, prop, msg)
`endif
`endif

// ===== rtl/sdtq_pkg.sv =====
// Shared types and constants of the sorted deadline timer queue.
// No dependencies; used by the interfaces, the cell and the top level.
package sdtq_pkg;

	localparam int OP_W    = 2;
	localparam int ID_W    = 4;
	localparam int DELAY_W = 31;
	localparam int CNT_W   = 5;

	localparam logic [CNT_W-1:0] MAX_RESULTS = 5'd16;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

	typedef enum logic [1:0] {
		ST_ADDED      = 2'd0,
		ST_DELETED    = 2'd1,
		ST_NOT_QUEUED = 2'd2,
		ST_EXPIRED    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_REMOVE = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_POP    = 2'd3
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t       cmd;
		logic [ID_W-1:0] id;
	} cell_ctrl_t;

	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} tag_t;

endpackage

// ===== rtl/sdtq_req_if.sv =====
// Request channel of the timer queue: operation, timer id and delay.
// Depends on sdtq_pkg.
interface sdtq_req_if;
	import sdtq_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [ID_W-1:0]    timer_id;
	logic [DELAY_W-1:0] delay;

	modport source (output valid, output operation, output timer_id, output delay,
		input ready);
	modport sink (input valid, input operation, input timer_id, input delay,
		output ready);
endinterface

// ===== rtl/sdtq_rsp_if.sv =====
// Response channel of the timer queue: status, timer id and last flag.
// Depends on sdtq_pkg.
interface sdtq_rsp_if;
	import sdtq_pkg::*;

	logic            valid;
	logic            ready;
	status_t         status;
	logic [ID_W-1:0] timer_id_res;
	logic            last;

	modport source (output valid, output status, output timer_id_res, output last,
		input ready);
	modport sink (input valid, input status, input timer_id_res, input last,
		output ready);
endinterface

// ===== rtl/sdtq_cell.sv =====
// One queue position of the timer queue: a timer id, its deadline and a valid bit.
// Depends on sdtq_pkg; shifts entries to and from its neighbours.
module sdtq_cell #(
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sdtq_pkg::cell_ctrl_t   ctrl,
	input  logic [TIME_BITS-1:0]   key,
	input  sdtq_pkg::tag_t         left_tag,
	input  logic [TIME_BITS-1:0]   left_dl,
	input  sdtq_pkg::tag_t         right_tag,
	input  logic [TIME_BITS-1:0]   right_dl,
	input  logic                   found_in,
	output sdtq_pkg::tag_t         tag,
	output logic [TIME_BITS-1:0]   dl,
	output logic                   found_out,
	output logic                   earlier,
	output logic                   match
);
	import sdtq_pkg::*;

	logic                 valid_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] dl_q;
	logic [TIME_BITS-1:0] diff;
	logic                 sel;
	tag_t                 tag_d;
	logic [TIME_BITS-1:0] dl_d;

	// wrap-safe: key strictly before deadline; an empty cell always accepts
	assign diff    = key - dl_q;
	assign earlier = !valid_q || diff[TIME_BITS-1];
	assign match   = valid_q && (id_q == ctrl.id);

	always_comb begin
		unique case (ctrl.cmd)
			CELL_REMOVE: sel = match;
			CELL_INSERT: sel = earlier;
			CELL_POP:    sel = 1'b1;
			default:     sel = 1'b0;
		endcase
	end

	assign found_out = found_in | sel;

	always_comb begin
		tag_d = '{valid: valid_q, id: id_q};
		dl_d  = dl_q;
		unique case (ctrl.cmd)
			CELL_REMOVE, CELL_POP: begin
				// close the gap: take the right neighbour
				if (found_out) begin
					tag_d = right_tag;
					dl_d  = right_dl;
				end
			end
			CELL_INSERT: begin
				// make room: take the left neighbour, or the new entry here
				if (found_in) begin
					tag_d = left_tag;
					dl_d  = left_dl;
				end else if (earlier) begin
					tag_d = '{valid: 1'b1, id: ctrl.id};
					dl_d  = key;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tag_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= tag_d.id;
		dl_q <= dl_d;
	end

	assign tag = '{valid: valid_q, id: id_q};
	assign dl  = dl_q;

endmodule

// ===== rtl/sorted_deadline_timer_queue.sv =====
// Sorted deadline timer queue: a row of TIMER_SLOTS cells, head in cell 0.
// Add: remove pass, then insert pass for an in-range id, then the result; next item after it.
// Delete: a remove pass, then the result. Tick: advances the time, then pops due heads,
// one expiry per cycle while the consumer takes each result (one pop of the cell row each).
// Reset (arst_n low) empties the row at once, clears the time and the response register.
`include "sorted_deadline_timer_queue_defines.svh"

module sorted_deadline_timer_queue #(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	sdtq_req_if.sink   req,
	sdtq_rsp_if.source rsp
);
	import sdtq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REMOVE,
		S_INSERT,
		S_EXPIRE
	} state_t;

	state_t               state_q;
	logic [OP_W-1:0]      op_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] time_q;
	logic [TIME_BITS-1:0] key_q;
	logic [CNT_W-1:0]     cnt_q;

	logic                 rsp_valid_q;
	status_t              rsp_status_q;
	logic [ID_W-1:0]      rsp_id_q;
	logic                 rsp_last_q;

	// cell row, padded with an empty entry at each end
	tag_t                 ent_tag [0:TIMER_SLOTS+1];
	logic [TIME_BITS-1:0] ent_dl  [0:TIMER_SLOTS+1];
	logic                 found   [0:TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] bef;
	logic [TIMER_SLOTS-1:0] match;
	logic [TIMER_SLOTS-1:0] vld;

	cell_ctrl_t cell_ctrl;
	logic       out_free;
	logic       in_range;
	logic       hit;
	logic       head_due;
	logic       next_due;
	logic       add_pass;
	logic       rsp_load;

	assign ent_tag[0]             = '0;
	assign ent_dl[0]              = '0;
	assign ent_tag[TIMER_SLOTS+1] = '0;
	assign ent_dl[TIMER_SLOTS+1]  = '0;
	assign found[0]               = 1'b0;

	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
		sdtq_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.key       (key_q),
			.left_tag  (ent_tag[i]),
			.left_dl   (ent_dl[i]),
			.right_tag (ent_tag[i+2]),
			.right_dl  (ent_dl[i+2]),
			.found_in  (found[i]),
			.tag       (ent_tag[i+1]),
			.dl        (ent_dl[i+1]),
			.found_out (found[i+1]),
			.earlier   (bef[i]),
			.match     (match[i])
		);
		assign vld[i] = ent_tag[i+1].valid;
	end

	// hold a result while the consumer stalls; free once it is taken
	assign out_free = !rsp_valid_q || rsp.ready;
	assign in_range = {5'd0, id_q} < 9'(TIMER_SLOTS);
	assign hit      = |match;
	assign add_pass = (op_q == OP_ADD) && in_range;

	// key_q holds the new time during a tick: head is due unless time is before it
	assign head_due = ent_tag[1].valid && !bef[0];
	assign next_due = ent_tag[2].valid && !bef[1];

	// load a new transaction into the response register this cycle
	assign rsp_load = out_free && (((state_q == S_REMOVE) && !add_pass) ||
		(state_q == S_INSERT) ||
		((state_q == S_EXPIRE) && head_due && (cnt_q != MAX_RESULTS)));

	always_comb begin
		cell_ctrl.id = id_q;
		unique case (state_q)
			S_REMOVE: cell_ctrl.cmd = (add_pass || out_free) ? CELL_REMOVE : CELL_HOLD;
			S_INSERT: cell_ctrl.cmd = out_free ? CELL_INSERT : CELL_HOLD;
			S_EXPIRE: cell_ctrl.cmd = (head_due && (cnt_q != MAX_RESULTS) && out_free)
				? CELL_POP : CELL_HOLD;
			default:  cell_ctrl.cmd = CELL_HOLD;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= '0;
			id_q         <= '0;
			time_q       <= '0;
			key_q        <= '0;
			cnt_q        <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_ADDED;
			rsp_id_q     <= '0;
			rsp_last_q   <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q <= req.operation;
						id_q <= req.timer_id;
						priority case (req.operation)
							OP_ADD: begin
								key_q   <= time_q + TIME_BITS'(req.delay);
								state_q <= S_REMOVE;
							end
							OP_DELETE: begin
								state_q <= S_REMOVE;
							end
							OP_TICK: begin
								// advance time, then drain due heads
								time_q  <= time_q + TIME_BITS'(1);
								key_q   <= time_q + TIME_BITS'(1);
								cnt_q   <= '0;
								state_q <= S_EXPIRE;
							end
							default: begin
							end
						endcase
					end
				end
				S_REMOVE: begin
					// drop any queued copy of the timer; an add of an in-range id goes on to insert
					if (add_pass) begin
						state_q <= S_INSERT;
					end else if (out_free) begin
						rsp_status_q <= (op_q == OP_DELETE && hit) ? ST_DELETED : ST_NOT_QUEUED;
						rsp_id_q     <= id_q;
						rsp_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_INSERT: begin
					if (out_free) begin
						rsp_status_q <= ST_ADDED;
						rsp_id_q     <= id_q;
						rsp_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_EXPIRE: begin
					if (!head_due || cnt_q == MAX_RESULTS) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						// pop the head; last when nothing further will expire this tick
						rsp_status_q <= ST_EXPIRED;
						rsp_id_q     <= ent_tag[1].id;
						rsp_last_q   <= (cnt_q == MAX_RESULTS - 5'd1) || !next_due;
						cnt_q        <= cnt_q + 5'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.timer_id_res = rsp_id_q;
	assign rsp.last         = rsp_last_q;

	`SDTQ_ASSERT(a_row_compact, (vld & (vld + TIMER_SLOTS'(1))) == '0, "cells not compact")
	`SDTQ_ASSERT(a_id_unique, $onehot0(match), "timer id queued in more than one cell")
	`SDTQ_ASSERT(a_insert_lands, cell_ctrl.cmd == CELL_INSERT |-> found[TIMER_SLOTS],
		"insert missed")
	`SDTQ_ASSERT(a_expiry_bound, cnt_q <= MAX_RESULTS, "too many expiries in one tick")
	`SDTQ_ASSERT(a_tick_advance, req.valid && req.ready && req.operation == OP_TICK |=>
		time_q == $past(time_q) + TIME_BITS'(1), "tick did not advance time")

endmodule
